// ===== hw/rtl/swsend_pkg.sv =====
// ----------------------------------------------------------------------------
// swsend_pkg
// Shared types and constants of the sliding window sender.
// ----------------------------------------------------------------------------
package swsend_pkg;

   // request kinds
   localparam logic [1:0] REQ_ACK     = 2'd0;
   localparam logic [1:0] REQ_SEND    = 2'd1;
   localparam logic [1:0] REQ_ADVANCE = 2'd2;

   // register map, selected by paddr[2]
   localparam logic REG_ADV_WIN  = 1'b0;
   localparam logic REG_CONG_WIN = 1'b1;

   localparam int          ADDR_W        = 3;
   localparam int          WIN_W         = 6;
   localparam logic [5:0]  ADV_WIN_RST   = 6'd20;
   localparam logic [5:0]  CONG_WIN_RST  = 6'd1;
   localparam logic [5:0]  MAX_WINDOW    = 6'd63;
   localparam int          RESULT_LIMIT  = 64;
   localparam int          CNT_W         = $clog2(RESULT_LIMIT);
   localparam logic [30:0] PRODUCED_MAX  = 31'h7FFF_FFFF;
   localparam logic [15:0] DUP_MAX       = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic capture;  // latch the request fields
      logic update;   // apply the request to the window state
      logic emit;     // produce one result this cycle
      logic last;     // the result produced is the final one
   } dp_cmd_type;

   typedef struct packed {
      logic can_send; // next_seq may go out now
      logic more;     // next_seq + 1 may go out after it
   } dp_sts_type;

endpackage

// ===== hw/rtl/swsend_csr.sv =====
// ----------------------------------------------------------------------------
// swsend_csr
// Window configuration registers behind the APB-style port.
// ----------------------------------------------------------------------------
module swsend_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [swsend_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic [swsend_pkg::WIN_W-1:0]   adv_win,
   output logic [swsend_pkg::WIN_W-1:0]   cong_win
);
   import swsend_pkg::*;

   logic [WIN_W-1:0] adv_win_ff, adv_win_in;
   logic [WIN_W-1:0] cong_win_ff, cong_win_in;
   logic             wr_en;

   assign wr_en = psel & penable & pwrite;

   always_comb begin
      adv_win_in  = adv_win_ff;
      cong_win_in = cong_win_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_ADV_WIN:  adv_win_in  = pwdata[WIN_W-1:0];
            REG_CONG_WIN: cong_win_in = pwdata[WIN_W-1:0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         adv_win_ff  <= ADV_WIN_RST;
         cong_win_ff <= CONG_WIN_RST;
      end else begin
         adv_win_ff  <= adv_win_in;
         cong_win_ff <= cong_win_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_ADV_WIN:  prdata = {{(32-WIN_W){1'b0}}, adv_win_ff};
         REG_CONG_WIN: prdata = {{(32-WIN_W){1'b0}}, cong_win_ff};
         default:      prdata = '0;
      endcase
   end

   assign adv_win  = adv_win_ff;
   assign cong_win = cong_win_ff;

endmodule

// ===== hw/rtl/swsend_ctrl.sv =====
// ----------------------------------------------------------------------------
// swsend_ctrl
// Sequencer: capture an item, update the window state, then emit results.
// ----------------------------------------------------------------------------
module swsend_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  swsend_pkg::dp_sts_type sts,
   output swsend_pkg::dp_cmd_type cmd
);
   import swsend_pkg::*;

   state_type state_ff, state_in;
   logic      final_rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      busy      = 1'b1;
      final_rsp = ~sts.can_send | ~sts.more;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_SEND;
         end
         ST_SEND: begin
            cmd.emit = 1'b1;
            cmd.last = final_rsp;
            if (final_rsp) begin
               // the burst ends here, so the next item may enter now
               busy = 1'b0;
               if (start) begin
                  cmd.capture = 1'b1;
                  state_in    = ST_UPDATE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/swsend_dp.sv =====
// ----------------------------------------------------------------------------
// swsend_dp
// Window state, send test and registered result outputs.
// ----------------------------------------------------------------------------
module swsend_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  swsend_pkg::dp_cmd_type         cmd,
   output swsend_pkg::dp_sts_type         sts,
   input  logic [1:0]                     req_type,
   input  logic [30:0]                    req_ack_seqno,
   input  logic [15:0]                    req_advance_count,
   input  logic [swsend_pkg::WIN_W-1:0]   adv_win,
   input  logic [swsend_pkg::WIN_W-1:0]   cong_win,
   output logic                           rsp_valid,
   output logic                           rsp_sent,
   output logic [30:0]                    rsp_tx_seqno,
   output logic                           rsp_last,
   output logic [15:0]                    rsp_dup_acks,
   output logic signed [31:0]             rsp_highest_sent
);
   import swsend_pkg::*;

   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RESULT_LIMIT - 1);

   // captured item
   logic [1:0]  type_ff;
   logic [30:0] ack_ff;
   logic [15:0] adv_ff;

   // window state
   logic [31:0]        next_ff, next_in;
   logic signed [31:0] ha_ff, ha_in;
   logic [30:0]        prod_ff, prod_in;
   logic signed [31:0] ms_ff, ms_in;
   logic [15:0]        dup_ff, dup_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // result registers
   logic               valid_ff;
   logic               sent_ff;
   logic [30:0]        seq_ff;
   logic               last_ff;
   logic [15:0]        dupo_ff;
   logic signed [31:0] hs_ff;

   logic [WIN_W-1:0]   win_min, win;
   logic signed [32:0] limit, next_ext, next_p1, prod_ext;
   logic signed [31:0] ack_ext;
   logic [31:0]        ack_p1;
   logic [31:0]        prod_sum;
   logic               can_send, more;

   // effective window and send test, plus a one-ahead test for the last flag
   assign win_min  = (cong_win < adv_win) ? cong_win : adv_win;
   assign win      = (win_min > MAX_WINDOW) ? MAX_WINDOW : win_min;
   assign limit    = $signed({ha_ff[31], ha_ff}) + $signed({{(33-WIN_W){1'b0}}, win});
   assign next_ext = $signed({1'b0, next_ff});
   assign next_p1  = next_ext + 33'sd1;
   assign prod_ext = $signed({2'b00, prod_ff});
   assign can_send = (next_ext <= limit) && (next_ext < prod_ext);
   assign more     = (cnt_ff != CNT_LAST) && (next_p1 <= limit) && (next_p1 < prod_ext);

   assign sts.can_send = can_send;
   assign sts.more     = more;

   assign ack_ext  = $signed({1'b0, ack_ff});
   assign ack_p1   = {1'b0, ack_ff} + 32'd1;
   assign prod_sum = {1'b0, prod_ff} + {16'd0, adv_ff};

   always_comb begin
      next_in = next_ff;
      ha_in   = ha_ff;
      prod_in = prod_ff;
      ms_in   = ms_ff;
      dup_in  = dup_ff;
      cnt_in  = cnt_ff;
      if (cmd.update) begin
         cnt_in = '0;
         case (type_ff)
            REQ_ACK: begin
               if (ack_ext == ha_ff) begin
                  if (dup_ff != DUP_MAX) begin
                     dup_in = dup_ff + 16'd1;
                  end
               end else if (ack_ext > ha_ff) begin
                  ha_in = ack_ext;
                  if (next_ff < ack_p1) begin
                     next_in = ack_p1;
                  end
               end
            end
            REQ_ADVANCE: begin
               prod_in = (prod_sum > {1'b0, PRODUCED_MAX}) ? PRODUCED_MAX : prod_sum[30:0];
            end
            default: ;
         endcase
      end
      if (cmd.emit && can_send) begin
         next_in = next_ff + 32'd1;
         cnt_in  = cnt_ff + 1'b1;
         if ($signed(next_ff) > ms_ff) begin
            ms_in = $signed(next_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         type_ff <= req_type;
         ack_ff  <= req_ack_seqno;
         adv_ff  <= req_advance_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff  <= '0;
         ha_ff    <= '1;
         prod_ff  <= '0;
         ms_ff    <= '1;
         dup_ff   <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         next_ff  <= next_in;
         ha_ff    <= ha_in;
         prod_ff  <= prod_in;
         ms_ff    <= ms_in;
         dup_ff   <= dup_in;
         cnt_ff   <= cnt_in;
         valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         sent_ff <= can_send;
         seq_ff  <= can_send ? next_ff[30:0] : 31'd0;
         last_ff <= cmd.last;
         dupo_ff <= dup_ff;
         hs_ff   <= ms_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_sent         = sent_ff;
   assign rsp_tx_seqno     = seq_ff;
   assign rsp_last         = last_ff;
   assign rsp_dup_acks     = dupo_ff;
   assign rsp_highest_sent = hs_ff;

endmodule

// ===== hw/rtl/sliding_window_sender.sv =====
// ----------------------------------------------------------------------------
// sliding_window_sender
// Window-limited sender: acks, send requests and produced-data advances.
// ----------------------------------------------------------------------------
// Flow: an item accepted in the idle state is captured, updates the window state
//   in the next cycle, and its results are registered onto the rsp_ ports.
// Each item causes 1 to 64 results, emitted one per cycle by the sequencer after
//   its state update; the next item can enter in the cycle of the final result.
// Results are strobed by rsp_valid for one cycle each; the receiver cannot stall.
// Reset (synchronous): windows return to 20 and 1, next_seq 0, produced 0,
//   dup count 0, highest ack and highest sent to -1, sequencer to idle.
// ----------------------------------------------------------------------------
module sliding_window_sender (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_type,
   input  logic [30:0]                   req_ack_seqno,
   input  logic [15:0]                   req_advance_count,
   // result channel
   output logic                          rsp_valid,
   output logic                          rsp_sent,
   output logic [30:0]                   rsp_tx_seqno,
   output logic                          rsp_last,
   output logic [15:0]                   rsp_dup_acks,
   output logic signed [31:0]            rsp_highest_sent,
   // configuration
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [swsend_pkg::ADDR_W-1:0] paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import swsend_pkg::*;

   logic [WIN_W-1:0] adv_win;
   logic [WIN_W-1:0] cong_win;
   dp_cmd_type       cmd;
   dp_sts_type       sts;

   // register writes complete in the access cycle, no wait states
   assign pready = 1'b1;

   swsend_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .adv_win  (adv_win),
      .cong_win (cong_win)
   );

   // sequencer: idle -> update -> send (one result per cycle) -> idle;
   // the next item can enter in the cycle of the final send
   swsend_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // datapath: window state, send test with one-ahead look for the last
   // flag, and the registered result outputs
   swsend_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_type          (req_type),
      .req_ack_seqno     (req_ack_seqno),
      .req_advance_count (req_advance_count),
      .adv_win           (adv_win),
      .cong_win          (cong_win),
      .rsp_valid         (rsp_valid),
      .rsp_sent          (rsp_sent),
      .rsp_tx_seqno      (rsp_tx_seqno),
      .rsp_last          (rsp_last),
      .rsp_dup_acks      (rsp_dup_acks),
      .rsp_highest_sent  (rsp_highest_sent)
   );

endmodule

// ===== hw/rtl/swsend_checker.sv =====
// ----------------------------------------------------------------------------
// swsend_checker
// Port-level checks of the sliding window sender, bound to the top level.
// ----------------------------------------------------------------------------
module swsend_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic               rsp_sent,
   input logic [30:0]        rsp_tx_seqno,
   input logic               rsp_last,
   input logic signed [31:0] rsp_highest_sent
);

   // an accepted item always occupies the state update cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low right after an accepted item");

   // an empty result is always the final one
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_sent) |-> rsp_last)
      else $error("empty result not marked last");

   // a sent number is always the new highest sent
   a_highest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_sent) |-> (rsp_highest_sent == $signed({1'b0, rsp_tx_seqno})))
      else $error("highest_sent does not follow the sent number");

   // a burst continues in the next cycle with the next consecutive number
   a_burst: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=>
         (rsp_valid && rsp_sent && (rsp_tx_seqno == $past(rsp_tx_seqno) + 31'd1)))
      else $error("burst broken or not consecutive");

endmodule

bind sliding_window_sender swsend_checker u_swsend_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_sent         (rsp_sent),
   .rsp_tx_seqno     (rsp_tx_seqno),
   .rsp_last         (rsp_last),
   .rsp_highest_sent (rsp_highest_sent)
);
